FILE: hdl/rl_pkg.sv
// Shared types and constants for the per-source rate limiter.
package rl_pkg;

    // Result status codes.
    localparam logic [1:0] STATUS_KNOWN_ALLOW  = 2'd0;
    localparam logic [1:0] STATUS_KNOWN_REJECT = 2'd1;
    localparam logic [1:0] STATUS_NEW_INSERT   = 2'd2;
    localparam logic [1:0] STATUS_NEW_EVICT    = 2'd3;

    // Configuration register map (word index) and reset value.
    localparam logic       REG_MIN_INTERVAL   = 1'b0;
    localparam logic [31:0] MIN_INTERVAL_RESET = 32'd1000;

    // Running search result handed from cell to cell along the chain.
    typedef struct packed {
        logic        hit;
        logic [31:0] hit_time;
        logic        free;
        logic        vic;
        logic [31:0] vic_time;
        logic [31:0] vic_addr;
    } rl_carry_t;

    // Table write command broadcast to all cells.
    typedef struct packed {
        logic        en;
        logic [31:0] addr;
        logic [31:0] stamp;
    } rl_write_t;

endpackage

FILE: hdl/rl_if.sv
// Valid/ready channel interfaces for requests and results.
interface rl_req_if;
    logic        valid;
    logic        ready;
    logic [31:0] source_addr;
    logic [31:0] now_ms;

    modport source (output valid, output source_addr, output now_ms, input ready);
    modport sink   (input valid, input source_addr, input now_ms, output ready);
endinterface

interface rl_rsp_if;
    logic       valid;
    logic       ready;
    logic       allowed;
    logic [1:0] status;

    modport source (output valid, output allowed, output status, input ready);
    modport sink   (input valid, input allowed, input status, output ready);
endinterface

FILE: hdl/per_source_rate_limiter_unit.sv
// Top level of the per-source minimum-interval rate limiter.
//
// Requests arrive on the req channel (source_addr, now_ms) and each one yields
// exactly one result on the rsp channel (allowed, status). The source table is
// a row of TABLE_ENTRIES cells. An accepted request is swept through the row,
// one cell per cycle, collecting the matching entry, the lowest free slot and
// the eviction candidate (oldest time, lowest address on ties). A final cycle
// decides the result and writes the table.
// A request passes from acceptance through the start register, the stage
// registers of the cell row and the decision state into the output register;
// one request is in flight at a time, so no new request is taken until the
// previous one has left the decision state.
// The result sits in an output register: if the receiver stalls, one more
// request can still be swept, then the block holds its decision in the final
// cycle until the register frees and takes no new request meanwhile.
// Reset empties the table (all entry valid bits clear) and sets the minimum
// interval to 1000 ms. The user must write the interval (APB-style port, byte
// address 0) only while no request is in flight; the block does not check it.
module per_source_rate_limiter_unit #(
    parameter int TABLE_ENTRIES = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    rl_req_if.sink      req,
    rl_rsp_if.source    rsp
);

    localparam int IW = $clog2(TABLE_ENTRIES);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BUSY = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [31:0]       req_addr_reg;
    logic [31:0]       req_now_reg;
    logic              start_reg;
    logic [31:0]       min_interval;
    logic              req_fire;
    logic              fin_fire;
    logic              chain_done;
    logic [31:0]       elapsed;

    logic              rsp_valid_reg;
    logic              allowed_reg;
    logic [1:0]        status_reg;
    logic              allowed_next;
    logic [1:0]        status_next;

    rl_pkg::rl_write_t wr;
    logic [IW-1:0]     wr_idx;

    logic              active_w   [TABLE_ENTRIES+1];
    rl_pkg::rl_carry_t carry_w    [TABLE_ENTRIES+1];
    logic [IW-1:0]     hit_idx_w  [TABLE_ENTRIES+1];
    logic [IW-1:0]     free_idx_w [TABLE_ENTRIES+1];
    logic [IW-1:0]     vic_idx_w  [TABLE_ENTRIES+1];

    // Configuration registers.
    rl_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .min_interval (min_interval)
    );

    // Handshakes.
    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign fin_fire  = (state_reg == ST_FIN) && (!rsp_valid_reg || rsp.ready);

    // Control state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (req_fire)   state_next = ST_BUSY;
            ST_BUSY: if (chain_done) state_next = ST_FIN;
            ST_FIN:  if (fin_fire)   state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            start_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= req_fire;
        end
    end

    // Captured request.
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            req_addr_reg <= req.source_addr;
            req_now_reg  <= req.now_ms;
        end
    end

    // Row of table cells; the search result moves one cell per cycle.
    assign active_w[0]   = start_reg;
    assign carry_w[0]    = '0;
    assign hit_idx_w[0]  = '0;
    assign free_idx_w[0] = '0;
    assign vic_idx_w[0]  = '0;

    for (genvar g = 0; g < TABLE_ENTRIES; g++)
    begin : g_cell
        rl_cell #(
            .IW      (IW),
            .CELL_ID (g)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .req_addr     (req_addr_reg),
            .active_in    (active_w[g]),
            .carry_in     (carry_w[g]),
            .hit_idx_in   (hit_idx_w[g]),
            .free_idx_in  (free_idx_w[g]),
            .vic_idx_in   (vic_idx_w[g]),
            .active_out   (active_w[g+1]),
            .carry_out    (carry_w[g+1]),
            .hit_idx_out  (hit_idx_w[g+1]),
            .free_idx_out (free_idx_w[g+1]),
            .vic_idx_out  (vic_idx_w[g+1]),
            .wr           (wr),
            .wr_idx       (wr_idx)
        );
    end

    assign chain_done = active_w[TABLE_ENTRIES];
    assign elapsed    = req_now_reg - carry_w[TABLE_ENTRIES].hit_time;

    // Decision and table update from the finished sweep.
    always_comb
    begin
        wr.en        = 1'b0;
        wr.addr      = req_addr_reg;
        wr.stamp     = req_now_reg;
        wr_idx       = vic_idx_w[TABLE_ENTRIES];
        allowed_next = 1'b1;
        status_next  = rl_pkg::STATUS_NEW_EVICT;
        if (carry_w[TABLE_ENTRIES].hit)
        begin
            wr_idx = hit_idx_w[TABLE_ENTRIES];
            if (elapsed < min_interval)
            begin
                allowed_next = 1'b0;
                status_next  = rl_pkg::STATUS_KNOWN_REJECT;
            end
            else
            begin
                wr.en       = fin_fire;
                status_next = rl_pkg::STATUS_KNOWN_ALLOW;
            end
        end
        else if (carry_w[TABLE_ENTRIES].free)
        begin
            wr.en       = fin_fire;
            wr_idx      = free_idx_w[TABLE_ENTRIES];
            status_next = rl_pkg::STATUS_NEW_INSERT;
        end
        else
        begin
            wr.en = fin_fire;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (fin_fire)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_fire)
        begin
            allowed_reg <= allowed_next;
            status_reg  <= status_next;
        end
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.allowed = allowed_reg;
    assign rsp.status  = status_reg;

    // An accepted request always starts a sweep.
    a_req_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> (state_reg == ST_BUSY) && start_reg)
        else $error("accepted request did not start a sweep");

    // The end of the row is reached only while a request is being searched.
    a_done_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        chain_done |-> (state_reg == ST_BUSY))
        else $error("sweep finished outside of a search");

    // A new result appears only after a decision cycle.
    a_rsp_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        fin_fire |=> rsp_valid_reg && (state_reg == ST_IDLE))
        else $error("decision did not load the output register");

    // Only a known source that came too soon is rejected.
    a_allowed_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (allowed_reg == (status_reg != rl_pkg::STATUS_KNOWN_REJECT)))
        else $error("allowed flag disagrees with status");

endmodule

FILE: hdl/rl_cell.sv
// One table cell: holds a single entry and folds it into the running search.
module rl_cell #(
    parameter int IW      = 5,
    parameter int CELL_ID = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [31:0]       req_addr,
    input  logic              active_in,
    input  rl_pkg::rl_carry_t carry_in,
    input  logic [IW-1:0]     hit_idx_in,
    input  logic [IW-1:0]     free_idx_in,
    input  logic [IW-1:0]     vic_idx_in,
    output logic              active_out,
    output rl_pkg::rl_carry_t carry_out,
    output logic [IW-1:0]     hit_idx_out,
    output logic [IW-1:0]     free_idx_out,
    output logic [IW-1:0]     vic_idx_out,
    input  rl_pkg::rl_write_t wr,
    input  logic [IW-1:0]     wr_idx
);

    localparam logic [IW-1:0] MY_IDX = IW'(CELL_ID);

    logic              valid_reg;
    logic [31:0]       addr_reg;
    logic [31:0]       time_reg;
    logic              active_reg;
    rl_pkg::rl_carry_t carry_reg;
    rl_pkg::rl_carry_t carry_next;
    logic [IW-1:0]     hit_idx_reg;
    logic [IW-1:0]     hit_idx_next;
    logic [IW-1:0]     free_idx_reg;
    logic [IW-1:0]     free_idx_next;
    logic [IW-1:0]     vic_idx_reg;
    logic [IW-1:0]     vic_idx_next;
    logic              wr_sel;
    logic              take_vic;

    assign wr_sel = wr.en && (wr_idx == MY_IDX);

    // Entry storage; the valid bit is cleared by reset, the payload is not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (wr_sel)
        begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_sel)
        begin
            addr_reg <= wr.addr;
            time_reg <= wr.stamp;
        end
    end

    // An older time wins; on equal times the lower address wins, earlier cells keep ties.
    assign take_vic = valid_reg &&
                      (!carry_in.vic || (time_reg < carry_in.vic_time) ||
                       ((time_reg == carry_in.vic_time) && (addr_reg < carry_in.vic_addr)));

    // Fold this entry into the search result passed along the chain.
    always_comb
    begin
        carry_next    = carry_in;
        hit_idx_next  = hit_idx_in;
        free_idx_next = free_idx_in;
        vic_idx_next  = vic_idx_in;
        if (valid_reg && !carry_in.hit && (addr_reg == req_addr))
        begin
            carry_next.hit      = 1'b1;
            carry_next.hit_time = time_reg;
            hit_idx_next        = MY_IDX;
        end
        if (!valid_reg && !carry_in.free)
        begin
            carry_next.free = 1'b1;
            free_idx_next   = MY_IDX;
        end
        if (take_vic)
        begin
            carry_next.vic      = 1'b1;
            carry_next.vic_time = time_reg;
            carry_next.vic_addr = addr_reg;
            vic_idx_next        = MY_IDX;
        end
    end

    // Stage register toward the next cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            carry_reg  <= '0;
        end
        else
        begin
            active_reg <= active_in;
            if (active_in)
            begin
                carry_reg <= carry_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (active_in)
        begin
            hit_idx_reg  <= hit_idx_next;
            free_idx_reg <= free_idx_next;
            vic_idx_reg  <= vic_idx_next;
        end
    end

    assign active_out   = active_reg;
    assign carry_out    = carry_reg;
    assign hit_idx_out  = hit_idx_reg;
    assign free_idx_out = free_idx_reg;
    assign vic_idx_out  = vic_idx_reg;

endmodule

FILE: hdl/rl_cfg.sv
// APB-style configuration register file holding the minimum interval.
module rl_cfg (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [31:0] min_interval
);

    logic [31:0] min_interval_reg;
    logic        reg_idx;

    assign reg_idx = paddr[2];
    assign pready  = 1'b1;

    // Register write on the access phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_interval_reg <= rl_pkg::MIN_INTERVAL_RESET;
        end
        else if (psel && penable && pwrite && (reg_idx == rl_pkg::REG_MIN_INTERVAL))
        begin
            min_interval_reg <= pwdata;
        end
    end

    // Read decode.
    always_comb
    begin
        unique case (reg_idx)
            rl_pkg::REG_MIN_INTERVAL: prdata = min_interval_reg;
            default:                  prdata = 32'd0;
        endcase
    end

    assign min_interval = min_interval_reg;

endmodule
